// File: hw/rtl/mtep_pkg.sv
package mtep_pkg;

    localparam int VLQ_MAX_BYTES = 5;
    localparam int TIME_BITS     = 32;

    localparam logic [7:0] DATA_MASK   = 8'h7F;
    localparam logic [7:0] STATUS_FLAG = 8'h80;
    localparam logic [7:0] SYSEX_BASE  = 8'hF0;
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;

    localparam logic [1:0] TEMPO_BYTES = 2'd3;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_CHAN,
        PH_MTYPE,
        PH_MLEN,
        PH_SLEN,
        PH_SKIP,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_META    = 2'd1,
        KIND_SYSEX   = 2'd2,
        KIND_ERROR   = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic        tempo_valid;
        logic [23:0] tempo_value;
        logic [7:0]  meta_kind;
        event_kind_t event_kind;
        logic [7:0]  note_velocity;
        logic [7:0]  note_key;
        logic [7:0]  status_byte;
        logic [31:0] event_time;
    } event_t;

endpackage

// File: hw/rtl/mtep_parser.sv
module mtep_parser
    import mtep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       track_end,
    output logic       res_valid,
    output event_t     res
);

    phase_t                 phase_reg, phase_next;
    logic [31:0]            delta_reg, delta_next;
    logic [2:0]             vlq_cnt_reg, vlq_cnt_next;
    logic [TIME_BITS-1:0]   ticks_reg, ticks_next;
    logic [7:0]             running_reg, running_next;
    logic [7:0]             cur_status_reg, cur_status_next;
    logic [7:0]             first_reg, first_next;
    logic [31:0]            skip_reg, skip_next;
    logic [7:0]             cur_meta_reg, cur_meta_next;
    logic [23:0]            tempo_reg, tempo_next;
    logic [1:0]             idx_reg, idx_next;

    logic [2:0]  vlq_cnt_inc;
    logic [31:0] vlq_shift;
    logic        vlq_done;
    logic        do_chan;
    logic [7:0]  chan_status;
    logic [1:0]  chan_idx;
    logic        emit_ms;
    logic        need_one;
    logic        is_note;
    logic        tempo_ok;

    assign vlq_cnt_inc = vlq_cnt_reg + 3'd1;
    assign vlq_shift   = {delta_reg[24:0], data_byte[6:0]};
    assign vlq_done    = ((data_byte & STATUS_FLAG) == 8'h00)
                         || (vlq_cnt_inc >= 3'(VLQ_MAX_BYTES));

    always_comb
    begin
        phase_next      = phase_reg;
        delta_next      = delta_reg;
        vlq_cnt_next    = vlq_cnt_reg;
        ticks_next      = ticks_reg;
        running_next    = running_reg;
        cur_status_next = cur_status_reg;
        first_next      = first_reg;
        skip_next       = skip_reg;
        cur_meta_next   = cur_meta_reg;
        tempo_next      = tempo_reg;
        idx_next        = idx_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.event_time  = 32'(ticks_reg);
        do_chan         = 1'b0;
        chan_status     = cur_status_reg;
        chan_idx        = idx_reg;
        emit_ms         = 1'b0;
        tempo_ok        = 1'b0;

        unique case (phase_reg)
            PH_STATUS:
            begin
                if (data_byte[7])
                begin
                    cur_status_next = data_byte;
                    idx_next        = 2'd0;
                    first_next      = 8'h00;
                    if (data_byte >= SYSEX_BASE)
                    begin
                        running_next = 8'h00;
                        delta_next   = 32'd0;
                        vlq_cnt_next = 3'd0;
                        phase_next   = (data_byte == META_STATUS) ? PH_MTYPE : PH_SLEN;
                    end
                    else
                    begin
                        running_next = data_byte;
                        phase_next   = PH_CHAN;
                    end
                end
                else if (running_reg == 8'h00)
                begin
                    phase_next     = PH_ERROR;
                    res_valid      = 1'b1;
                    res.event_kind = KIND_ERROR;
                end
                else
                begin
                    cur_status_next = running_reg;
                    idx_next        = 2'd0;
                    first_next      = 8'h00;
                    do_chan         = 1'b1;
                    chan_status     = running_reg;
                    chan_idx        = 2'd0;
                end
            end
            PH_CHAN:
            begin
                do_chan = 1'b1;
            end
            PH_MTYPE:
            begin
                cur_meta_next = data_byte;
                delta_next    = 32'd0;
                vlq_cnt_next  = 3'd0;
                phase_next    = PH_MLEN;
            end
            PH_MLEN, PH_SLEN:
            begin
                delta_next   = vlq_shift;
                vlq_cnt_next = vlq_cnt_inc;
                if (vlq_done)
                begin
                    skip_next  = vlq_shift;
                    tempo_next = 24'd0;
                    idx_next   = 2'd0;
                    if (vlq_shift == 32'd0)
                        emit_ms = 1'b1;
                    else
                        phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if ((cur_status_reg == META_STATUS) && (cur_meta_reg == META_TEMPO)
                    && (idx_reg < TEMPO_BYTES))
                begin
                    tempo_next = {tempo_reg[15:0], data_byte};
                    idx_next   = idx_reg + 2'd1;
                end
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                    emit_ms = 1'b1;
            end
            PH_ERROR:
            begin
                phase_next = PH_ERROR;
            end
            PH_DELTA:
            begin
                delta_next   = vlq_shift;
                vlq_cnt_next = vlq_cnt_inc;
                if (vlq_done)
                begin
                    ticks_next = ticks_reg + TIME_BITS'(vlq_shift);
                    phase_next = PH_STATUS;
                end
            end
            default:
            begin
                phase_next = PH_DELTA;
            end
        endcase

        need_one = (chan_status[7:4] == HI_PROGRAM) || (chan_status[7:4] == HI_PRESSURE);
        is_note  = (chan_status[7:4] == HI_NOTE_OFF) || (chan_status[7:4] == HI_NOTE_ON);

        if (do_chan)
        begin
            res.status_byte = chan_status;
            res.event_kind  = KIND_CHANNEL;
            if (chan_idx == 2'd0)
            begin
                first_next = data_byte;
                idx_next   = 2'd1;
                if (!need_one)
                    phase_next = PH_CHAN;
                else
                begin
                    phase_next   = PH_DELTA;
                    delta_next   = 32'd0;
                    vlq_cnt_next = 3'd0;
                    res_valid    = 1'b1;
                end
            end
            else
            begin
                phase_next        = PH_DELTA;
                delta_next        = 32'd0;
                vlq_cnt_next      = 3'd0;
                res_valid         = 1'b1;
                res.note_key      = is_note ? first_reg : 8'h00;
                res.note_velocity = is_note ? data_byte : 8'h00;
            end
        end

        if (emit_ms)
        begin
            phase_next   = PH_DELTA;
            delta_next   = 32'd0;
            vlq_cnt_next = 3'd0;
            res_valid    = 1'b1;
            if (cur_status_reg == META_STATUS)
            begin
                tempo_ok        = (cur_meta_reg == META_TEMPO) && (idx_next == TEMPO_BYTES);
                res.status_byte = META_STATUS;
                res.event_kind  = KIND_META;
                res.meta_kind   = cur_meta_reg;
                res.tempo_value = tempo_ok ? tempo_next : 24'd0;
                res.tempo_valid = tempo_ok;
            end
            else
            begin
                res.status_byte = cur_status_reg;
                res.event_kind  = KIND_SYSEX;
            end
        end

        if (track_end)
        begin
            phase_next      = PH_DELTA;
            delta_next      = 32'd0;
            vlq_cnt_next    = 3'd0;
            ticks_next      = '0;
            running_next    = 8'h00;
            cur_status_next = 8'h00;
            first_next      = 8'h00;
            skip_next       = 32'd0;
            cur_meta_next   = 8'h00;
            tempo_next      = 24'd0;
            idx_next        = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DELTA;
            delta_reg      <= 32'd0;
            vlq_cnt_reg    <= 3'd0;
            ticks_reg      <= '0;
            running_reg    <= 8'h00;
            cur_status_reg <= 8'h00;
            first_reg      <= 8'h00;
            skip_reg       <= 32'd0;
            cur_meta_reg   <= 8'h00;
            tempo_reg      <= 24'd0;
            idx_reg        <= 2'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            delta_reg      <= delta_next;
            vlq_cnt_reg    <= vlq_cnt_next;
            ticks_reg      <= ticks_next;
            running_reg    <= running_next;
            cur_status_reg <= cur_status_next;
            first_reg      <= first_next;
            skip_reg       <= skip_next;
            cur_meta_reg   <= cur_meta_next;
            tempo_reg      <= tempo_next;
            idx_reg        <= idx_next;
        end
    end

endmodule

// File: hw/rtl/midi_track_event_parser.sv
// Parses the payload of a standard MIDI file track, one byte per beat.
// The slave side takes one track byte in tdata; tlast marks the last byte of
// the track, after which all parser state, the tick count included, returns
// to its reset value. The master side gives one beat per completed event:
// tdata holds the absolute tick time, status, note key, note velocity, meta
// type and tempo, and tuser holds the event kind and the tempo flag.
// A byte passes through an input register and then the parser, and each result
// is held in an output register that drives the master side.
// The parser takes one byte in every cycle while the receiver does not stall;
// bytes that complete no event give no beat at all.
// Reset is asynchronous and active low; it empties both registers and puts
// the parser back to expecting a delta time.
// When the receiver stalls, the result is held in the output register and
// one further byte may wait in the input register; tready then falls until
// the result is taken.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // track_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_time, status_byte, note_key, note_velocity, meta_kind, tempo_value
    output logic [87:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // event_kind, tempo_valid
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    event_t     out_res_reg;
    logic       advance;
    logic       res_valid;
    event_t     res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    mtep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .track_end (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        out_valid_next = out_valid_reg;
        if (advance && res_valid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && res_valid)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.tempo_value, out_res_reg.meta_kind,
                            out_res_reg.note_velocity, out_res_reg.note_key,
                            out_res_reg.status_byte, out_res_reg.event_time};
    assign m_axis_tuser  = {out_res_reg.tempo_valid, out_res_reg.event_kind};

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input byte lost while the parser was stalled");

    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("tready low without a full pipeline");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(advance))
        else $error("result appeared without a parser step");

    a_tempo_meta: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == KIND_META)
        else $error("tempo flag set on a non-meta event");

    a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == KIND_ERROR |-> m_axis_tdata[39:32] == 8'h00)
        else $error("missing status event carries a status byte");

endmodule

// File: tb/tb_midi_track_event_parser.sv
`timescale 1ns / 1ps

module tb_midi_track_event_parser;
    import mtep_pkg::*;

    localparam int RANDOM_BYTES = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    midi_track_event_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser state as the block should hold it.
    phase_t               parse_state;
    logic [31:0]          delta_acc;
    logic [2:0]           vlq_count;
    logic [TIME_BITS-1:0] tick_count;
    logic [7:0]           running_status;
    logic [7:0]           cur_status;
    logic [7:0]           first_byte;
    logic [31:0]          skip_left;
    logic [7:0]           cur_meta;
    logic [23:0]          tempo_acc;
    logic [1:0]           data_count;

    event_t      pending_events[$];
    event_t      oldest_event;
    logic [7:0]  track_bytes[$];

    int          fail_count = 0;
    int          bytes_accepted = 0;
    int          cycle_count = 0;
    int          tx_burst = 0;
    int          rx_burst = 0;
    int          rx_hold_cycles = 0;
    bit          tx_no_gaps = 1'b0;
    bit          gen_running_live = 1'b0;

    function automatic void reset_parser();
        parse_state    = PH_DELTA;
        delta_acc      = '0;
        vlq_count      = '0;
        tick_count     = '0;
        running_status = '0;
        cur_status     = '0;
        first_byte     = '0;
        skip_left      = '0;
        cur_meta       = '0;
        tempo_acc      = '0;
        data_count     = '0;
    endfunction

    function automatic bit vlq_absorb(input logic [7:0] b);
        delta_acc = {delta_acc[24:0], b[6:0]};
        vlq_count = vlq_count + 3'd1;
        return (!b[7]) || (vlq_count >= VLQ_MAX_BYTES);
    endfunction

    function automatic void post_event(input logic [7:0] status, input logic [7:0] key,
                                       input logic [7:0] velocity, input event_kind_t kind,
                                       input logic [7:0] meta, input logic [23:0] tempo,
                                       input logic tempo_ok);
        event_t ev;
        ev.event_time    = 32'(tick_count);
        ev.status_byte   = status;
        ev.note_key      = key;
        ev.note_velocity = velocity;
        ev.event_kind    = kind;
        ev.meta_kind     = meta;
        ev.tempo_value   = tempo;
        ev.tempo_valid   = tempo_ok;
        pending_events.push_back(ev);
    endfunction

    function automatic void close_meta_or_sysex();
        logic tempo_ok;
        parse_state = PH_DELTA;
        delta_acc   = '0;
        vlq_count   = '0;
        if (cur_status == META_STATUS)
        begin
            tempo_ok = (cur_meta == META_TEMPO) && (data_count == TEMPO_BYTES);
            post_event(META_STATUS, 8'h00, 8'h00, KIND_META, cur_meta,
                       tempo_ok ? tempo_acc : 24'h0, tempo_ok);
        end
        else
        begin
            post_event(cur_status, 8'h00, 8'h00, KIND_SYSEX, 8'h00, 24'h0, 1'b0);
        end
    endfunction

    function automatic void take_channel_data(input logic [7:0] b);
        logic one_byte;
        logic is_note;
        one_byte = (cur_status[7:4] == HI_PROGRAM) || (cur_status[7:4] == HI_PRESSURE);
        is_note  = (cur_status[7:4] == HI_NOTE_OFF) || (cur_status[7:4] == HI_NOTE_ON);
        if (data_count == 2'd0)
        begin
            first_byte = b;
            data_count = 2'd1;
            if (!one_byte)
            begin
                parse_state = PH_CHAN;
                return;
            end
            parse_state = PH_DELTA;
            delta_acc   = '0;
            vlq_count   = '0;
            post_event(cur_status, 8'h00, 8'h00, KIND_CHANNEL, 8'h00, 24'h0, 1'b0);
            return;
        end
        parse_state = PH_DELTA;
        delta_acc   = '0;
        vlq_count   = '0;
        post_event(cur_status, is_note ? first_byte : 8'h00, is_note ? b : 8'h00,
                   KIND_CHANNEL, 8'h00, 24'h0, 1'b0);
    endfunction

    function automatic void parse_track_byte(input logic [7:0] b, input logic last);
        case (parse_state)
            PH_STATUS:
            begin
                if (b[7])
                begin
                    cur_status = b;
                    data_count = 2'd0;
                    first_byte = 8'h00;
                    if (b >= SYSEX_BASE)
                    begin
                        running_status = 8'h00;
                        delta_acc      = '0;
                        vlq_count      = '0;
                        parse_state    = (b == META_STATUS) ? PH_MTYPE : PH_SLEN;
                    end
                    else
                    begin
                        running_status = b;
                        parse_state    = PH_CHAN;
                    end
                end
                else if (running_status == 8'h00)
                begin
                    parse_state = PH_ERROR;
                    post_event(8'h00, 8'h00, 8'h00, KIND_ERROR, 8'h00, 24'h0, 1'b0);
                end
                else
                begin
                    cur_status = running_status;
                    data_count = 2'd0;
                    first_byte = 8'h00;
                    take_channel_data(b);
                end
            end
            PH_CHAN:
            begin
                take_channel_data(b);
            end
            PH_MTYPE:
            begin
                cur_meta    = b;
                delta_acc   = '0;
                vlq_count   = '0;
                parse_state = PH_MLEN;
            end
            PH_MLEN, PH_SLEN:
            begin
                if (vlq_absorb(b))
                begin
                    skip_left  = delta_acc;
                    tempo_acc  = '0;
                    data_count = 2'd0;
                    if (skip_left == 32'd0)
                        close_meta_or_sysex();
                    else
                        parse_state = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (cur_status == META_STATUS && cur_meta == META_TEMPO
                    && data_count < TEMPO_BYTES)
                begin
                    tempo_acc  = {tempo_acc[15:0], b};
                    data_count = data_count + 2'd1;
                end
                skip_left = skip_left - 32'd1;
                if (skip_left == 32'd0)
                    close_meta_or_sysex();
            end
            PH_ERROR:
            begin
            end
            default:
            begin
                if (vlq_absorb(b))
                begin
                    tick_count  = tick_count + TIME_BITS'(delta_acc);
                    parse_state = PH_STATUS;
                end
            end
        endcase
        if (last)
            reset_parser();
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            parse_track_byte(s_axis_tdata, s_axis_tlast);
            bytes_accepted++;
        end
    end

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s differs, expected %0h, got %0h", $time, name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %h / %h",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                oldest_event = pending_events.pop_front();
                check_field("event_time", oldest_event.event_time, m_axis_tdata[31:0]);
                check_field("status_byte", 32'(oldest_event.status_byte),
                            32'(m_axis_tdata[39:32]));
                check_field("note_key", 32'(oldest_event.note_key),
                            32'(m_axis_tdata[47:40]));
                check_field("note_velocity", 32'(oldest_event.note_velocity),
                            32'(m_axis_tdata[55:48]));
                check_field("meta_kind", 32'(oldest_event.meta_kind),
                            32'(m_axis_tdata[63:56]));
                check_field("tempo_value", 32'(oldest_event.tempo_value),
                            32'(m_axis_tdata[87:64]));
                check_field("event_kind", 32'(oldest_event.event_kind),
                            32'(m_axis_tuser[1:0]));
                check_field("tempo_valid", 32'(oldest_event.tempo_valid),
                            32'(m_axis_tuser[2]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("midi_track_event_parser: mismatch");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_burst > 0)
            begin
                gap = 0;
                rx_burst--;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                gap      = 0;
                rx_burst = $urandom_range(20, 80);
            end
            else
            begin
                gap = $urandom_range(0, 15);
            end
            if (rx_hold_cycles > 0)
            begin
                gap            = gap + rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_track_byte(input logic [7:0] b, input logic last);
        int gap;
        if (tx_no_gaps || tx_burst > 0)
        begin
            gap = 0;
            if (tx_burst > 0)
                tx_burst--;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            gap      = 0;
            tx_burst = $urandom_range(20, 80);
        end
        else
        begin
            gap = $urandom_range(0, 15);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_frame(input bit close_track);
        foreach (track_bytes[i])
            send_track_byte(track_bytes[i], close_track && (i == track_bytes.size() - 1));
        track_bytes.delete();
        if (close_track)
            gen_running_live = 1'b0;
    endtask

    task automatic push_vlq(input logic [31:0] value, input bit pad);
        logic [7:0]  groups[$];
        logic [31:0] rest;
        rest = value;
        groups.push_front({1'b0, rest[6:0]});
        rest = rest >> 7;
        while (rest != 0)
        begin
            groups.push_front({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        if (pad)
            groups.push_front(8'h80);
        foreach (groups[i])
            track_bytes.push_back(groups[i]);
    endtask

    task automatic push_random_delta();
        case ($urandom_range(0, 9))
            0:       repeat (5) track_bytes.push_back({1'b1, 7'($urandom)});
            1:       push_vlq($urandom, 1'b0);
            2, 3:    push_vlq($urandom_range(0, 16383), $urandom_range(0, 3) == 0);
            default: push_vlq($urandom_range(0, 127), $urandom_range(0, 3) == 0);
        endcase
    endtask

    task automatic push_data_byte(input bit allow_high);
        if (allow_high && $urandom_range(0, 7) == 0)
            track_bytes.push_back(8'($urandom));
        else
            track_bytes.push_back({1'b0, 7'($urandom)});
    endtask

    task automatic push_payload(input int len);
        repeat (len) track_bytes.push_back(8'($urandom));
    endtask

    task automatic test_channel_messages();
        track_bytes = '{8'h00, 8'h90, 8'h00, 8'h7F,
                        8'h7F, 8'hDF, 8'h7F,
                        8'h00, 8'h22};
        send_frame(1'b1);
    endtask

    task automatic test_meta_tempo();
        // A full tempo, then a tempo with no payload after a two-byte delta.
        track_bytes = '{8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                        8'h81, 8'h00, 8'hFF, 8'h51, 8'h00};
        send_frame(1'b0);
    endtask

    task automatic test_error_and_truncation();
        // Over-long delta, then a data byte with no running status left.
        track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05, 8'h30};
        send_frame(1'b1);
        track_bytes = '{8'h00, 8'h90, 8'h7F};
        send_frame(1'b1);
    endtask

    task automatic test_output_stall();
        tx_no_gaps     = 1'b1;
        rx_hold_cycles = STALL_CYCLES;
        track_bytes = '{8'h00, 8'h90};
        push_data_byte(1'b0);
        push_data_byte(1'b0);
        repeat (15)
        begin
            track_bytes.push_back(8'h00);
            push_data_byte(1'b0);
            push_data_byte(1'b0);
        end
        send_frame(1'b1);
        tx_no_gaps = 1'b0;
    endtask

    task automatic test_random_tracks();
        int         start_count;
        int         pick;
        int         len;
        int         cut;
        bit         close_track;
        logic [7:0] status;
        logic [7:0] meta_type;
        start_count = bytes_accepted;
        while (bytes_accepted - start_count < RANDOM_BYTES)
        begin
            close_track = ($urandom_range(0, 29) == 0);
            pick = $urandom_range(0, 99);
            push_random_delta();
            if (pick < 40 || (pick < 65 && !gen_running_live))
            begin
                status = {4'($urandom_range(8, 14)), 4'($urandom)};
                track_bytes.push_back(status);
                push_data_byte(1'b1);
                if (status[7:4] != HI_PROGRAM && status[7:4] != HI_PRESSURE)
                    push_data_byte(1'b1);
                gen_running_live = 1'b1;
            end
            else if (pick < 65)
            begin
                push_data_byte(1'b0);
                if (status[7:4] != HI_PROGRAM && status[7:4] != HI_PRESSURE)
                    push_data_byte(1'b1);
            end
            else if (pick < 78)
            begin
                meta_type = ($urandom_range(0, 1) == 1) ? META_TEMPO : 8'($urandom);
                if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(6, 20);
                else if (meta_type == META_TEMPO && $urandom_range(0, 3) != 0)
                    len = 3;
                else
                    len = $urandom_range(0, 5);
                track_bytes.push_back(META_STATUS);
                track_bytes.push_back(meta_type);
                push_vlq(len, $urandom_range(0, 3) == 0);
                push_payload(len);
                gen_running_live = 1'b0;
            end
            else if (pick < 88)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 20)
                                                   : $urandom_range(0, 5);
                track_bytes.push_back(8'($urandom_range(8'hF0, 8'hFE)));
                push_vlq(len, $urandom_range(0, 3) == 0);
                push_payload(len);
                gen_running_live = 1'b0;
            end
            else if (pick < 92)
            begin
                // An empty meta event cancels running status, so the data byte
                // that follows in the status position is an error.
                track_bytes.push_back(META_STATUS);
                track_bytes.push_back(8'($urandom));
                track_bytes.push_back(8'h00);
                push_random_delta();
                push_data_byte(1'b0);
                push_payload($urandom_range(0, 3));
                close_track = 1'b1;
            end
            else if (pick < 96)
            begin
                push_payload($urandom_range(1, 4));
                close_track = 1'b1;
            end
            else
            begin
                len = $urandom_range(3, 6);
                track_bytes.push_back(META_STATUS);
                track_bytes.push_back(META_TEMPO);
                push_vlq(len, 1'b0);
                push_payload(len);
                cut = $urandom_range(1, track_bytes.size());
                while (track_bytes.size() > cut)
                    void'(track_bytes.pop_back());
                close_track = 1'b1;
            end
            send_frame(close_track);
        end
    endtask

    initial
    begin
        reset_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_channel_messages();
        test_meta_tempo();
        test_error_and_truncation();
        test_output_stall();
        test_random_tracks();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_events.size() == 0)
        begin
            $display("midi_track_event_parser: match");
        end
        else
        begin
            $display("midi_track_event_parser: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_parser.sv
hw/rtl/midi_track_event_parser.sv
tb/tb_midi_track_event_parser.sv
